### hw/rtl/monotonic_max_queue_defines.svh
// Assertion helpers shared by the queue RTL.
`ifndef MONOTONIC_MAX_QUEUE_DEFINES_SVH
`define MONOTONIC_MAX_QUEUE_DEFINES_SVH

// Concurrent check on the rising clock, suspended while reset is held.
`define MMQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define MMQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

### hw/rtl/mmq_pkg.sv
package mmq_pkg;

	// Default geometry of the window.
	localparam int DEFAULT_WINDOW_DEPTH = 64;
	localparam int DEFAULT_VALUE_WIDTH  = 16;

	// Operation carried in the input beat's user field.
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	// Status reported with every result beat.
	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic push;   // insert a new value behind the kept entries
		logic shift;  // drop the front entry, every cell takes its right neighbour
	} cell_ctrl_t;

endpackage

### hw/rtl/monotonic_max_queue.sv
// Sliding-window maximum queue built as a row of compare-and-shift cells.
// Input beats arrive on s_tvalid/s_tready: s_tuser[0] is the operation
// (0 push, 1 pop) and s_tdata holds the signed sample for a push.
// Every accepted beat produces exactly one result beat on m_tvalid/m_tready:
// m_tdata carries the window maximum (zero when empty), the empty flag, the
// element count and an error code (pop on empty or push on full, both ignored).
// Each item is processed in one step: all cells compare the new sample in
// parallel and the front cell's next value is the new maximum, so the result
// is registered in the cycle after acceptance; one item per cycle is sustained
// while the receiver does not stall. The step is set by the cell compare and
// the one-deep output register; an accepted beat never waits on the chain itself.
// When the receiver stalls, the result is held in the output register and a
// new beat is taken only in a cycle in which that register empties.
// Reset clears all cell occupancy flags, the counters and the output valid;
// the window is empty right after reset and no clearing pass is needed.
`include "monotonic_max_queue_defines.svh"

module monotonic_max_queue #(
	parameter int WINDOW_DEPTH = mmq_pkg::DEFAULT_WINDOW_DEPTH,
	parameter int VALUE_WIDTH  = mmq_pkg::DEFAULT_VALUE_WIDTH,
	localparam int IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8,
	localparam int CNT_W       = $clog2(WINDOW_DEPTH + 1),
	localparam int OUT_RAW_W   = VALUE_WIDTH + 1 + CNT_W + 2,
	localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // value, zero padding
	input  logic [0:0]            s_tuser,  // opcode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // max_value, is_empty, window_size, error_code, pad
);

	localparam int TAG_W    = $clog2(WINDOW_DEPTH) + 1;
	localparam int EMPTY_LO = VALUE_WIDTH;
	localparam int SIZE_LO  = VALUE_WIDTH + 1;
	localparam int ERR_LO   = VALUE_WIDTH + 1 + CNT_W;

	logic                   fire;
	mmq_pkg::op_t           op;
	logic [VALUE_WIDTH-1:0] in_value;
	logic                   full;
	logic                   empty;
	logic                   push_ok;
	logic                   pop_ok;
	logic                   drop;
	mmq_pkg::cell_ctrl_t    ctrl;
	mmq_pkg::err_t          err;
	logic [CNT_W-1:0]       count_d;

	logic [CNT_W-1:0]       count_q;
	logic [TAG_W-1:0]       head_seq_q;
	logic [TAG_W-1:0]       tail_seq_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_max_q;
	logic                   out_empty_q;
	logic [CNT_W-1:0]       out_size_q;
	mmq_pkg::err_t          out_err_q;

	logic [WINDOW_DEPTH-1:0] cell_valid;
	logic [WINDOW_DEPTH-1:0] cell_keep;
	logic [WINDOW_DEPTH-1:0] cell_d_valid;
	logic [VALUE_WIDTH-1:0]  cell_value   [WINDOW_DEPTH];
	logic [VALUE_WIDTH-1:0]  cell_d_value [WINDOW_DEPTH];
	logic [TAG_W-1:0]        cell_tag     [WINDOW_DEPTH];

	// Input handshake: a beat is taken whenever the result register is free.
	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;
	assign op       = mmq_pkg::op_t'(s_tuser[0]);
	assign in_value = s_tdata[VALUE_WIDTH-1:0];

	// Operation decode and error classification.
	assign full    = (count_q == CNT_W'(WINDOW_DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = fire && (op == mmq_pkg::OP_PUSH) && !full;
	assign pop_ok  = fire && (op == mmq_pkg::OP_POP) && !empty;
	// The front entry leaves once its last covered element is the oldest one.
	assign drop       = pop_ok && (cell_tag[0] == head_seq_q);
	assign ctrl.push  = push_ok;
	assign ctrl.shift = drop;

	always_comb begin
		err = mmq_pkg::ERR_OK;
		if (fire && (op == mmq_pkg::OP_PUSH) && full) begin
			err = mmq_pkg::ERR_FULL;
		end else if (fire && (op == mmq_pkg::OP_POP) && empty) begin
			err = mmq_pkg::ERR_EMPTY;
		end
	end

	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (pop_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// The chain of cells; the front of the window sits in cell 0.
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		logic                   prev_keep;
		logic                   nxt_valid;
		logic [VALUE_WIDTH-1:0] nxt_value;
		logic [TAG_W-1:0]       nxt_tag;

		if (i == 0) begin : g_first
			assign prev_keep = 1'b1;
		end else begin : g_inner
			assign prev_keep = cell_keep[i-1];
		end

		if (i == WINDOW_DEPTH - 1) begin : g_last
			assign nxt_valid = 1'b0;
			assign nxt_value = '0;
			assign nxt_tag   = '0;
		end else begin : g_link
			assign nxt_valid = cell_valid[i+1];
			assign nxt_value = cell_value[i+1];
			assign nxt_tag   = cell_tag[i+1];
		end

		mmq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.TAG_WIDTH  (TAG_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.push_value(in_value),
			.push_tag  (tail_seq_q),
			.prev_keep (prev_keep),
			.nxt_valid (nxt_valid),
			.nxt_value (nxt_value),
			.nxt_tag   (nxt_tag),
			.valid     (cell_valid[i]),
			.keep      (cell_keep[i]),
			.value     (cell_value[i]),
			.tag       (cell_tag[i]),
			.d_valid   (cell_d_valid[i]),
			.d_value   (cell_d_value[i])
		);
	end

	// Element counters: sequence numbers of the oldest and the next element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			head_seq_q <= '0;
			tail_seq_q <= '0;
		end else begin
			count_q <= count_d;
			if (push_ok) begin
				tail_seq_q <= tail_seq_q + TAG_W'(1);
			end
			if (pop_ok) begin
				head_seq_q <= head_seq_q + TAG_W'(1);
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, taken from the front cell's next state.
	always_ff @(posedge clk) begin
		if (fire) begin
			out_max_q   <= cell_d_valid[0] ? cell_d_value[0] : '0;
			out_empty_q <= (count_d == '0);
			out_size_q  <= count_d;
			out_err_q   <= err;
		end
	end

	// Pack the result beat.
	assign m_tvalid = out_valid_q;
	always_comb begin
		m_tdata                          = '0;
		m_tdata[VALUE_WIDTH-1:0]         = out_max_q;
		m_tdata[EMPTY_LO]                = out_empty_q;
		m_tdata[SIZE_LO +: CNT_W]        = out_size_q;
		m_tdata[ERR_LO +: 2]             = out_err_q;
	end

	// The element count never passes the window depth.
	`MMQ_ASSERT(a_count_bound, count_q <= CNT_W'(WINDOW_DEPTH), "element count above depth")
	// Occupied cells form a contiguous run from the front.
	`MMQ_ASSERT(a_cells_packed, ((cell_valid + WINDOW_DEPTH'(1)) & cell_valid) == '0,
		"gap in the cell chain")
	// Every stored entry covers at least one element.
	`MMQ_ASSERT(a_cells_le_count, $countones(cell_valid) <= count_q,
		"more stored entries than elements")
	// The front cell is occupied exactly when the window holds elements.
	`MMQ_ASSERT(a_front_matches_count, cell_valid[0] == (count_q != '0),
		"front cell disagrees with element count")
	// Every accepted beat yields a result in the following cycle.
	`MMQ_ASSERT(a_result_follows, fire |=> out_valid_q, "accepted beat without result")
	// The result register is empty straight after reset.
	`MMQ_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid_q || arst_n,
		"result valid during reset")

endmodule

### hw/rtl/mmq_cell.sv
module mmq_cell #(
	parameter int VALUE_WIDTH = mmq_pkg::DEFAULT_VALUE_WIDTH,
	parameter int TAG_WIDTH   = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mmq_pkg::cell_ctrl_t    ctrl,
	input  logic [VALUE_WIDTH-1:0] push_value,
	input  logic [TAG_WIDTH-1:0]   push_tag,
	input  logic                   prev_keep,
	input  logic                   nxt_valid,
	input  logic [VALUE_WIDTH-1:0] nxt_value,
	input  logic [TAG_WIDTH-1:0]   nxt_tag,
	output logic                   valid,
	output logic                   keep,
	output logic [VALUE_WIDTH-1:0] value,
	output logic [TAG_WIDTH-1:0]   tag,
	output logic                   d_valid,
	output logic [VALUE_WIDTH-1:0] d_value
);

	logic                   valid_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [TAG_WIDTH-1:0]   tag_q;
	logic [TAG_WIDTH-1:0]   d_tag;

	// An entry survives a push only when it is strictly greater than the new value.
	assign keep  = valid_q && ($signed(value_q) > $signed(push_value));
	assign valid = valid_q;
	assign value = value_q;
	assign tag   = tag_q;

	// Next state: keep, take the new value at the boundary, clear, or shift left.
	always_comb begin
		d_valid = valid_q;
		d_value = value_q;
		d_tag   = tag_q;
		if (ctrl.push) begin
			if (!keep) begin
				if (prev_keep) begin
					d_valid = 1'b1;
					d_value = push_value;
					d_tag   = push_tag;
				end else begin
					d_valid = 1'b0;
				end
			end
		end else if (ctrl.shift) begin
			d_valid = nxt_valid;
			d_value = nxt_value;
			d_tag   = nxt_tag;
		end
	end

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d_valid;
		end
	end

	// Payload of the entry.
	always_ff @(posedge clk) begin
		value_q <= d_value;
		tag_q   <= d_tag;
	end

endmodule

### dv/monotonic_max_queue_tb.sv
module monotonic_max_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH          = mmq_pkg::DEFAULT_WINDOW_DEPTH;
	localparam int SAMPLE_W       = mmq_pkg::DEFAULT_VALUE_WIDTH;
	localparam int SIZE_W         = $clog2(DEPTH + 1);
	localparam int RESULT_W       = 32;
	localparam int TOTAL_BEATS    = 500;
	localparam int CLOSING_BEATS  = 60;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 20;

	// Value styles used by the random part.
	typedef enum int {
		PICK_ANY,
		PICK_NARROW,
		PICK_EXTREME,
		PICK_FALLING
	} pick_t;

	// One result beat, split into its fields.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] max_value;
		logic                       is_empty;
		logic [SIZE_W-1:0]          window_size;
		mmq_pkg::err_t              error_code;
	} window_result_t;

	// Predicts the window after each accepted beat and checks the result beats.
	class window_scoreboard;
		typedef struct {
			logic signed [SAMPLE_W-1:0] value;
			int unsigned                absorbed;
		} run_t;

		run_t           runs[$];
		int unsigned    elements;
		window_result_t awaited[$];
		int unsigned    failures;

		task flag_mismatch(string what, int got, int want);
			$display("mismatch: %s got %0d expected %0d (%0d results awaited)",
				what, got, want, awaited.size());
			failures++;
		endtask

		// Applies an accepted beat to the predicted window and queues its result.
		task note_input(mmq_pkg::op_t op, logic signed [SAMPLE_W-1:0] sample);
			window_result_t r;
			run_t           fresh;
			r.error_code = mmq_pkg::ERR_OK;
			if (op == mmq_pkg::OP_PUSH) begin
				if (elements >= DEPTH) begin
					r.error_code = mmq_pkg::ERR_FULL;
				end else begin
					// Smaller or equal runs at the back fold into the new one.
					fresh.value = sample;
					fresh.absorbed = 0;
					while (runs.size() > 0 && runs[$].value <= sample) begin
						fresh.absorbed += runs[$].absorbed + 1;
						runs.delete(runs.size() - 1);
					end
					runs.insert(runs.size(), fresh);
					elements++;
				end
			end else begin
				if (elements == 0) begin
					r.error_code = mmq_pkg::ERR_EMPTY;
				end else begin
					if (runs[0].absorbed == 0)
						void'(runs.pop_front());
					else
						runs[0].absorbed--;
					elements--;
				end
			end
			r.max_value = (runs.size() > 0) ? runs[0].value : '0;
			r.is_empty = (elements == 0);
			r.window_size = elements[SIZE_W-1:0];
			awaited.insert(awaited.size(), r);
		endtask

		// Compares one result beat with the oldest prediction.
		task check_result(logic [RESULT_W-1:0] beat);
			window_result_t want;
			logic signed [SAMPLE_W-1:0] got_max;
			logic                       got_empty;
			logic [SIZE_W-1:0]          got_size;
			logic [1:0]                 got_err;
			got_max = beat[SAMPLE_W-1:0];
			got_empty = beat[SAMPLE_W];
			got_size = beat[SAMPLE_W+SIZE_W:SAMPLE_W+1];
			got_err = beat[SAMPLE_W+SIZE_W+2:SAMPLE_W+SIZE_W+1];
			if (awaited.size() == 0) begin
				flag_mismatch("result beat with nothing awaited, max", got_max, 0);
			end else begin
				want = awaited.pop_front();
				if (got_max !== want.max_value)
					flag_mismatch("max_value", got_max, want.max_value);
				if (got_empty !== want.is_empty)
					flag_mismatch("is_empty", got_empty, want.is_empty);
				if (got_size !== want.window_size)
					flag_mismatch("window_size", got_size, want.window_size);
				if (got_err !== want.error_code)
					flag_mismatch("error_code", got_err, want.error_code);
			end
		endtask

		task note_leftovers();
			if (awaited.size() != 0)
				flag_mismatch("results never delivered, count", awaited.size(), 0);
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata;
	logic [0:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [RESULT_W-1:0] m_tdata;

	window_scoreboard          book;
	int unsigned               beats_sent;
	bit                        closing_stretch;
	bit                        hold_off_request;
	logic signed [SAMPLE_W-1:0] falling_sample;

	monotonic_max_queue i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result monitor: a beat moves at a rising edge with both handshake lines high.
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
			book.check_result(m_tdata);
	end

	// Offers one beat and waits for it to be taken, then maybe idles for a burst.
	task automatic offer_beat(input mmq_pkg::op_t op,
			input logic signed [SAMPLE_W-1:0] sample);
		s_tuser <= op;
		s_tdata <= sample;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		book.note_input(op, sample);
		beats_sent++;
		if (beats_sent >= TOTAL_BEATS - CLOSING_BEATS)
			closing_stretch = 1'b1;
		@(negedge clk);
		if (!closing_stretch && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(pick_t style);
		logic signed [SAMPLE_W-1:0] s;
		case (style)
			PICK_NARROW: begin
				s = SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(3);
			end
			PICK_EXTREME: begin
				case ($urandom_range(0, 3))
					0: s = {1'b1, {(SAMPLE_W-1){1'b0}}};
					1: s = {1'b0, {(SAMPLE_W-1){1'b1}}};
					2: s = '1;
					default: s = '0;
				endcase
			end
			PICK_FALLING: begin
				// Strictly falling runs keep every sample as its own stored entry.
				falling_sample = falling_sample - SAMPLE_W'($urandom_range(1, 400));
				s = falling_sample;
			end
			default: begin
				s = SAMPLE_W'($urandom);
			end
		endcase
		return s;
	endfunction

	// A run of beats with a given share of pushes and one style of sample.
	task automatic run_segment(input int unsigned beats, input int unsigned push_share,
			input pick_t style);
		for (int unsigned k = 0; k < beats; k++) begin
			if ($urandom_range(0, 99) < push_share)
				offer_beat(mmq_pkg::OP_PUSH, pick_sample(style));
			else
				offer_beat(mmq_pkg::OP_POP, SAMPLE_W'($urandom));
		end
	endtask

	// Receiver: random stall bursts, one long hold-off on request, none at the close.
	initial begin : receiver
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				m_tready <= 1'b0;
				for (int c = 0; c < HOLD_OFF_CYCLES; c++)
					@(negedge clk);
				hold_off_request = 1'b0;
				m_tready <= 1'b1;
			end else if (!closing_stretch && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		book = new();
		beats_sent = 0;
		closing_stretch = 1'b0;
		hold_off_request = 1'b0;
		falling_sample = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = mmq_pkg::OP_PUSH;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty pops, extremes, equal samples and absorption.
		offer_beat(mmq_pkg::OP_POP, 16'sh1234);
		offer_beat(mmq_pkg::OP_PUSH, 16'sh8000);
		offer_beat(mmq_pkg::OP_PUSH, 16'sh7FFF);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);
		offer_beat(mmq_pkg::OP_POP, 16'shFFFF);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);
		offer_beat(mmq_pkg::OP_PUSH, 16'sd5);
		offer_beat(mmq_pkg::OP_PUSH, 16'sd5);
		offer_beat(mmq_pkg::OP_PUSH, 16'sd5);
		offer_beat(mmq_pkg::OP_PUSH, 16'sd3);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);
		offer_beat(mmq_pkg::OP_PUSH, -16'sd1);
		offer_beat(mmq_pkg::OP_PUSH, 16'sd0);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);
		offer_beat(mmq_pkg::OP_PUSH, 16'sh5555);
		offer_beat(mmq_pkg::OP_PUSH, 16'shAAAA);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);
		offer_beat(mmq_pkg::OP_POP, 16'sh0000);

		// Fill past full with distinct falling samples while the receiver holds off,
		// then drain past empty.
		hold_off_request = 1'b1;
		falling_sample = 16'sd32000;
		run_segment(DEPTH + 6, 100, PICK_FALLING);
		run_segment(DEPTH + 4, 0, PICK_ANY);

		// Random part: segments that fill, drain or hover with varied samples.
		while (beats_sent < TOTAL_BEATS) begin
			falling_sample = SAMPLE_W'($urandom_range(16000, 32767));
			case ($urandom_range(0, 3))
				0: run_segment($urandom_range(20, 80), 90, pick_t'($urandom_range(0, 3)));
				1: run_segment($urandom_range(20, 60), 15, pick_t'($urandom_range(0, 3)));
				default: run_segment($urandom_range(20, 60), 55,
					pick_t'($urandom_range(0, 3)));
			endcase
		end
		s_tvalid <= 1'b0;

		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		book.note_leftovers();
		if (book.failures == 0)
			$display("** monotonic_max_queue: PASSED **");
		else
			$display("** monotonic_max_queue: FAILED **");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin : watchdog
		#4ms;
		$display("** monotonic_max_queue: FAILED **");
		$finish;
	end

endmodule
